// ===== hdl/ehtk_pkg.sv =====
// Shared types and constants for the event histogram top-k unit.
// No dependencies; every other file except ehtk_ram imports this package.
`timescale 1ns / 1ps

package ehtk_pkg;

  // Default sizing, handed to the top level parameters
  localparam int BIN_COUNT_DEF = 4096 + 1;
  localparam int TOP_SIZE_DEF  = 16;

  // Fixed field widths
  localparam int EVENT_W = 64;
  localparam int RANK_W  = 4;
  localparam int BINID_W = 13;
  localparam int COUNT_W = 64;

  // Opcode values of an input beat
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [EVENT_W-1:0] event_id;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [BINID_W-1:0] bin_id;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] grand_total;
    logic               last_item;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;      // write zero at the sweep address
    logic rec_rd;      // read the bin of the incoming event
    logic rec_wr;      // write back the incremented bin
    logic scan_start;  // restart sweep address, list, total, emit count
    logic scan_rd;     // read the bin at the sweep address
    logic ins_en;      // read data of a sweep read is valid this cycle
    logic emit_shift;  // result beat taken: advance the list
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_last;   // sweep address is the last bin
    logic rec_hit;     // incoming event number lies below the bin count
    logic list_empty;  // no entry in the top list
    logic emit_last;   // head entry is the final one of the report
  } sts_t;

endpackage

// ===== hdl/ehtk_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ehtk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ehtk_ctrl.sv =====
// Controller of the event histogram top-k unit: clear pass, record,
// sweep and result sequencing. Depends on ehtk_pkg.
`timescale 1ns / 1ps

module ehtk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ehtk_pkg::sts_t sts,
  output ehtk_pkg::cmd_t cmd
);

  import ehtk_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ins_en_r;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_REPORT) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else if (sts.rec_hit) begin
            cmd.rec_rd = 1'b1;
            state_nxt  = ST_REC_WR;
          end
        end
      end
      ST_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.list_empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          cmd.emit_shift = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.ins_en = ins_en_r;
  end

  // Hold state and the delayed sweep-read flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ins_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ins_en_r <= (state_r == ST_SCAN);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

// ===== hdl/ehtk_dpath.sv =====
// Datapath of the event histogram top-k unit: bin memory, sweep address,
// sorted top list, saturating total and result payload.
// Depends on ehtk_pkg and ehtk_ram.
`timescale 1ns / 1ps

module ehtk_dpath #(
  parameter int BIN_COUNT = ehtk_pkg::BIN_COUNT_DEF,
  parameter int TOP_SIZE  = ehtk_pkg::TOP_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ehtk_pkg::cmd_t                cmd,
  input  logic [ehtk_pkg::EVENT_W-1:0]  in_event,
  output ehtk_pkg::sts_t                sts,
  output ehtk_pkg::out_item_t           out_data
);

  import ehtk_pkg::*;

  localparam int AW = $clog2(BIN_COUNT);
  localparam int UW = $clog2(TOP_SIZE + 1);

  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      scan_id_r;
  logic [AW-1:0]      raddr;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] wdata;
  logic [COUNT_W-1:0] bin_inc;
  logic               ins;
  logic [COUNT_W:0]   total_sum;
  logic [COUNT_W-1:0] total_r;
  logic [UW-1:0]      used_r;
  logic [UW-1:0]      emit_cnt_r;

  logic [AW-1:0]       top_id_r   [TOP_SIZE];
  logic [COUNT_W-1:0]  top_cnt_r  [TOP_SIZE];
  logic [AW-1:0]       ins_id     [TOP_SIZE];
  logic [COUNT_W-1:0]  ins_cnt    [TOP_SIZE];
  logic [AW-1:0]       sh_id      [TOP_SIZE];
  logic [COUNT_W-1:0]  sh_cnt     [TOP_SIZE];
  logic [TOP_SIZE-1:0] take;

  logic [UW+RANK_W-1:0] rank_ext;
  logic [AW+BINID_W-1:0] id_ext;

  // Bin memory
  assign raddr   = cmd.rec_rd ? in_event[AW-1:0] : addr_r;
  assign bin_inc = (&rd_data) ? rd_data : rd_data + COUNT_W'(1);
  assign wdata   = cmd.clr_wr ? '0 : bin_inc;

  ehtk_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.rec_wr),
    .waddr (addr_r),
    .wdata (wdata),
    .re    (cmd.rec_rd | cmd.scan_rd),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Sweep and record address; starts at zero for the clear pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      priority if (cmd.scan_start) begin
        addr_r <= '0;
      end else if (cmd.rec_rd) begin
        addr_r <= in_event[AW-1:0];
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // Remember which bin the sweep read returns next cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      scan_id_r <= addr_r;
    end
  end

  // Insert only non-empty bins
  assign ins       = cmd.ins_en && (rd_data != '0);
  assign total_sum = {1'b0, total_r} + {1'b0, rd_data};

  // Sorted insertion: take marks slots at or after the insertion point
  for (genvar k = 0; k < TOP_SIZE; k++) begin : g_slot
    assign take[k] = (UW'(k) < used_r) ? (rd_data > top_cnt_r[k]) : 1'b1;
    if (k == 0) begin : g_head
      assign ins_id[k]  = take[k] ? scan_id_r : top_id_r[k];
      assign ins_cnt[k] = take[k] ? rd_data   : top_cnt_r[k];
    end else begin : g_body
      assign ins_id[k]  = take[k] ? (take[k-1] ? top_id_r[k-1] : scan_id_r)
                                  : top_id_r[k];
      assign ins_cnt[k] = take[k] ? (take[k-1] ? top_cnt_r[k-1] : rd_data)
                                  : top_cnt_r[k];
    end
    if (k < TOP_SIZE - 1) begin : g_shift
      assign sh_id[k]  = top_id_r[k+1];
      assign sh_cnt[k] = top_cnt_r[k+1];
    end else begin : g_tail
      assign sh_id[k]  = top_id_r[k];
      assign sh_cnt[k] = top_cnt_r[k];
    end
  end

  // Top list entries: insert during the sweep, advance while emitting
  always_ff @(posedge clk) begin
    priority if (ins) begin
      top_id_r  <= ins_id;
      top_cnt_r <= ins_cnt;
    end else if (cmd.emit_shift) begin
      top_id_r  <= sh_id;
      top_cnt_r <= sh_cnt;
    end
  end

  // List length and emit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      if (cmd.scan_start) begin
        used_r <= '0;
      end else if (ins && (used_r != UW'(TOP_SIZE))) begin
        used_r <= used_r + UW'(1);
      end
      if (cmd.scan_start) begin
        emit_cnt_r <= '0;
      end else if (cmd.emit_shift) begin
        emit_cnt_r <= emit_cnt_r + UW'(1);
      end
    end
  end

  // Saturating total of all counts
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      total_r <= '0;
    end else if (ins) begin
      total_r <= total_sum[COUNT_W] ? '1 : total_sum[COUNT_W-1:0];
    end
  end

  // Status to the controller
  assign sts.addr_last  = (addr_r == AW'(BIN_COUNT - 1));
  assign sts.rec_hit    = (in_event[EVENT_W-1:AW] == '0) &&
                          ({1'b0, in_event[AW-1:0]} < (AW+1)'(BIN_COUNT));
  assign sts.list_empty = (used_r == '0);
  assign sts.emit_last  = ((emit_cnt_r + UW'(1)) == used_r);

  // Result payload straight from the list head
  assign rank_ext             = {{RANK_W{1'b0}}, emit_cnt_r};
  assign id_ext               = {{BINID_W{1'b0}}, top_id_r[0]};
  assign out_data.rank        = rank_ext[RANK_W-1:0];
  assign out_data.bin_id      = id_ext[BINID_W-1:0];
  assign out_data.bin_count   = top_cnt_r[0];
  assign out_data.grand_total = total_r;
  assign out_data.last_item   = sts.emit_last;

endmodule

// ===== hdl/event_histogram_top_k_unit.sv =====
// Record: a beat reads its bin, then writes back the saturating increment while inputs are
// stalled; out-of-range events are dropped. Report: a sweep with one bin memory read per
// cycle, then one result per cycle while out_stall is low, up to TOP_SIZE results.
// Inputs are stalled from the report beat until its last result is taken.
// Reset: synchronous, active low; then a clearing pass over all BIN_COUNT bins (4097 by default)
// zeroes the bins while inputs are stalled.
`timescale 1ns / 1ps

module event_histogram_top_k_unit #(
  parameter int BIN_COUNT = ehtk_pkg::BIN_COUNT_DEF,
  parameter int TOP_SIZE  = ehtk_pkg::TOP_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ehtk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ehtk_pkg::out_item_t out_data
);

  import ehtk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  ehtk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  ehtk_dpath #(
    .BIN_COUNT (BIN_COUNT),
    .TOP_SIZE  (TOP_SIZE)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_event (in_data.event_id),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== hdl/ehtk_checker.sv =====
// Port-level checks for the event histogram top-k unit, bound to the top level.
// Depends on ehtk_pkg and event_histogram_top_k_unit.
`timescale 1ns / 1ps

module ehtk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ehtk_pkg::out_item_t out_data
);

  import ehtk_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A report run opens at rank zero
  a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.rank == '0)
    else $error("report run does not start at rank zero");

  // Inside a run, beats follow without gaps at the next rank and same total
  a_next_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_item |=>
      out_valid && (out_data.rank == $past(out_data.rank) + RANK_W'(1)) &&
      (out_data.grand_total == $past(out_data.grand_total)))
    else $error("report run broken between beats");

  // The last beat ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_item |=> !out_valid)
    else $error("result beat after the last one");

  // No input is taken while a report is delivering
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during result delivery");

endmodule

bind event_histogram_top_k_unit ehtk_checker u_ehtk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
